FILE: sv/i2c_master_byte_engine_macros.svh
// assertion macros shared by the i2c byte engine rtl
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// condition must hold at every edge out of reset
`define I2CM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define I2CM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/i2cm_pkg.sv
// types and constants of the i2c byte engine
`default_nettype none
package i2cm_pkg;

    localparam int CMD_W   = 3;
    localparam int STEP_W  = 5;
    localparam int TICK_W  = 16;
    localparam int BYTE_W  = 8;

    localparam logic [CMD_W-1:0] CMD_START    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_ACK = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_NAK = 3'd4;

    localparam logic [STEP_W-1:0] STEP_IDLE       = 5'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST      = 5'd1;
    localparam logic [STEP_W-1:0] STEP_STOP_SCL   = 5'd2;
    localparam logic [STEP_W-1:0] STEP_LAST_START = 5'd2;
    localparam logic [STEP_W-1:0] STEP_LAST_STOP  = 5'd3;
    localparam logic [STEP_W-1:0] STEP_LAST_BIT   = 5'd16;
    localparam logic [STEP_W-1:0] STEP_ACK_SET    = 5'd17;
    localparam logic [STEP_W-1:0] STEP_LAST_BYTE  = 5'd18;

    localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;

    localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  active;
        logic [STEP_W-1:0] step;
        logic [TICK_W-1:0] tick;
        logic [BYTE_W-1:0] shift;
        logic              scl;
        logic              sda;
        logic              ack;
        logic [BYTE_W-1:0] rd;
    } t_state;

    typedef struct packed {
        logic              scl_level;
        logic              sda_release;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_byte;
        logic              ack_seen;
    } t_result;

endpackage
`default_nettype wire

FILE: sv/i2c_master_byte_engine.sv
// top level of the single-master i2c byte engine
// each input item is one tick of the bus timing engine and yields exactly one result
// item, so the block takes one item per cycle for as long as the output side is not
// stalled. the bus state (command, phase step, tick counter, shift byte and line levels)
// lives in registers that advance on every accepted item; the next state comes from one
// short pass of logic in i2cm_step and is mirrored into a result register, so a result
// reaches the output in the cycle after its item is accepted. the input is stalled only while
// a finished result is held and the output side stalls. each bus phase lasts phase_ticks
// ticks (zero behaves as one); commands that arrive while busy, and unknown command
// codes, are dropped. there is no clock stretching and no arbitration.
`default_nettype none
`include "i2c_master_byte_engine_macros.svh"
module i2c_master_byte_engine (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration: phase length in ticks
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [i2cm_pkg::TICK_W-1:0]      i_cfg_data,
    // input item channel
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire                             i_command_valid,
    input  wire [i2cm_pkg::CMD_W-1:0]       i_command,
    input  wire [i2cm_pkg::BYTE_W-1:0]      i_write_byte,
    input  wire                             i_sda_in,
    // result item channel
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic                            o_scl_level,
    output logic                            o_sda_release,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic [i2cm_pkg::BYTE_W-1:0]     o_read_byte,
    output logic                            o_ack_seen
);
    import i2cm_pkg::*;

    logic [TICK_W-1:0] r_phase_ticks;
    t_state            r_state;
    t_state            n_state;
    t_result           step_result;
    t_result           out_result;
    logic              in_fire;

    // register writes are always taken at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_phase_ticks <= i_cfg_data;
        end
    end

    assign in_fire = i_in_valid && !o_in_stall;

    // one tick of bus sequencing
    i2cm_step u_step (
        .i_state         (r_state),
        .i_command_valid (i_command_valid),
        .i_command       (i_command),
        .i_write_byte    (i_write_byte),
        .i_sda_in        (i_sda_in),
        .i_phase_ticks   (r_phase_ticks),
        .o_state         (n_state),
        .o_result        (step_result)
    );

    // bus state only moves on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.active <= CMD_START;
            r_state.step   <= STEP_IDLE;
            r_state.tick   <= '0;
            r_state.shift  <= '0;
            r_state.scl    <= 1'b1;
            r_state.sda    <= 1'b1;
            r_state.ack    <= 1'b0;
            r_state.rd     <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // result register parts the input side from the output side
    i2cm_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_fire),
        .i_result     (step_result),
        .i_out_stall  (i_out_stall),
        .o_full_stall (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_result     (out_result)
    );

    assign o_scl_level   = out_result.scl_level;
    assign o_sda_release = out_result.sda_release;
    assign o_busy_res    = out_result.busy_res;
    assign o_done_res    = out_result.done_res;
    assign o_read_byte   = out_result.read_byte;
    assign o_ack_seen    = out_result.ack_seen;

    // checks on the sequencer and the output stage
    `I2CM_ASSERT_ALWAYS(a_step_range, i_clk, i_rst_n, r_state.step <= STEP_LAST_BYTE, "phase step out of range")
    `I2CM_ASSERT_IMPLIES(a_idle_tick_clear, i_clk, i_rst_n, r_state.step == STEP_IDLE, r_state.tick == '0, "tick counter running while idle")
    `I2CM_ASSERT_IMPLIES(a_done_not_busy, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res, "done reported while still busy")
    `I2CM_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, in_fire, o_out_valid, "accepted item left no result")

endmodule
`default_nettype wire

FILE: sv/i2cm_step.sv
// next bus state and result for one tick
`default_nettype none
module i2cm_step (
    input  wire i2cm_pkg::t_state          i_state,
    input  wire                            i_command_valid,
    input  wire [i2cm_pkg::CMD_W-1:0]      i_command,
    input  wire [i2cm_pkg::BYTE_W-1:0]     i_write_byte,
    input  wire                            i_sda_in,
    input  wire [i2cm_pkg::TICK_W-1:0]     i_phase_ticks,
    output i2cm_pkg::t_state               o_state,
    output i2cm_pkg::t_result              o_result
);
    import i2cm_pkg::*;

    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] tick_inc;
    logic [STEP_W-1:0] last_step;
    logic              do_enter;
    logic              done;
    logic              is_write;
    logic              is_byte;
    t_state            nx;

    always_comb begin
        limit     = (i_phase_ticks == '0) ? TICK_W'(1) : i_phase_ticks;
        tick_inc  = i_state.tick + TICK_W'(1);
        nx        = i_state;
        do_enter  = 1'b0;
        done      = 1'b0;
        last_step = STEP_LAST_BYTE;
        if (i_state.active == CMD_START) begin
            last_step = STEP_LAST_START;
        end else if (i_state.active == CMD_STOP) begin
            last_step = STEP_LAST_STOP;
        end

        if (i_state.step == STEP_IDLE) begin
            if (i_command_valid && (i_command <= CMD_READ_NAK)) begin
                nx.active = i_command;
                nx.tick   = '0;
                nx.shift  = (i_command == CMD_WRITE) ? i_write_byte : '0;
                nx.step   = STEP_FIRST;
                do_enter  = 1'b1;
            end
        end else begin
            nx.tick = tick_inc;
            if (tick_inc >= limit) begin
                nx.tick = '0;
                if (i_state.step >= last_step) begin
                    // finishing action
                    if (i_state.active != CMD_STOP) begin
                        nx.scl = 1'b0;
                    end
                    if (i_state.active == CMD_READ_ACK || i_state.active == CMD_READ_NAK) begin
                        nx.rd = i_state.shift;
                    end
                    nx.step = STEP_IDLE;
                    done    = 1'b1;
                end else begin
                    nx.step  = i_state.step + STEP_W'(1);
                    do_enter = 1'b1;
                end
            end
        end

        is_write = (nx.active == CMD_WRITE);
        is_byte  = (nx.active != CMD_START) && (nx.active != CMD_STOP);

        // levels set on the first tick of a phase
        if (do_enter) begin
            if (nx.active == CMD_START) begin
                if (nx.step == STEP_FIRST) begin
                    nx.scl = 1'b1;
                    nx.sda = 1'b1;
                end else begin
                    nx.sda = 1'b0;
                end
            end else if (nx.active == CMD_STOP) begin
                if (nx.step == STEP_FIRST) begin
                    nx.scl = 1'b0;
                    nx.sda = 1'b0;
                end else if (nx.step == STEP_STOP_SCL) begin
                    nx.scl = 1'b1;
                end else begin
                    nx.sda = 1'b1;
                end
            end else if (is_byte && nx.step <= STEP_LAST_BIT) begin
                if (nx.step[0]) begin
                    // scl low half of a bit, data set up
                    if (nx.step != STEP_FIRST) begin
                        nx.scl = 1'b0;
                    end
                    if (is_write) begin
                        nx.sda   = ((nx.shift & MSB_MASK) != '0);
                        nx.shift = {nx.shift[BYTE_W-2:0], 1'b0};
                    end else if (nx.step == STEP_FIRST) begin
                        nx.sda = 1'b1;
                    end
                end else begin
                    nx.scl = 1'b1;
                    if (!is_write) begin
                        nx.shift = {nx.shift[BYTE_W-2:0], i_sda_in};
                    end
                end
            end else if (nx.step == STEP_ACK_SET) begin
                nx.scl = 1'b0;
                nx.sda = (nx.active == CMD_READ_ACK) ? 1'b0 : 1'b1;
            end else begin
                nx.scl = 1'b1;
                if (is_write) begin
                    nx.ack = ~i_sda_in;
                end
            end
        end
    end

    assign o_state              = nx;
    assign o_result.scl_level   = nx.scl;
    assign o_result.sda_release = nx.sda;
    assign o_result.busy_res    = (nx.step != STEP_IDLE);
    assign o_result.done_res    = done;
    assign o_result.read_byte   = nx.rd;
    assign o_result.ack_seen    = nx.ack;

endmodule
`default_nettype wire

FILE: sv/i2cm_out_reg.sv
// result register between the engine and the output channel
`default_nettype none
module i2cm_out_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  wire i2cm_pkg::t_result i_result,
    input  wire                 i_out_stall,
    output logic                o_full_stall,
    output logic                o_out_valid,
    output i2cm_pkg::t_result   o_result
);
    import i2cm_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_data;

    // can take a new item when empty or when the held item leaves now
    assign o_full_stall = r_valid && i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_data;

endmodule
`default_nettype wire
